### rtl/core/acrs_pkg.sv
package acrs_pkg;

    localparam int MAX_SPANS = 64;
    localparam int AW        = 32;
    localparam int CW        = $clog2(MAX_SPANS + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CHECK  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [AW-1:0] ANGLE_TOP = '1;

    typedef logic [MAX_SPANS-1:0] t_vec;

    typedef enum logic [2:0] {
        C_KEEP,
        C_TAKE_NEXT,
        C_TAKE_PREV,
        C_LOAD_NEW,
        C_SET_START,
        C_SET_END,
        C_END_FROM_NEXT
    } t_cell_op;

    typedef struct packed {
        logic lt;
        logic enclosed;
        logic contain;
        logic in_a;
        logic in_b;
        logic le;
        logic zero;
    } t_flags;

    function automatic t_vec first_of(input t_vec x);
        t_vec r;
        logic seen;
        seen = 1'b0;
        for (int j = 0; j < MAX_SPANS; j++) begin
            r[j] = x[j] & ~seen;
            seen = seen | x[j];
        end
        return r;
    endfunction

    function automatic t_vec from_first(input t_vec x);
        t_vec r;
        logic seen;
        seen = 1'b0;
        for (int j = 0; j < MAX_SPANS; j++) begin
            seen = seen | x[j];
            r[j] = seen;
        end
        return r;
    endfunction

endpackage

### rtl/core/acrs_cell.sv
module acrs_cell
    import acrs_pkg::*;
(
    input  logic          i_clk,
    input  t_cell_op      i_op,
    input  logic [AW-1:0] i_s,
    input  logic [AW-1:0] i_e,
    input  logic [AW-1:0] i_prev_start,
    input  logic [AW-1:0] i_prev_end,
    input  logic [AW-1:0] i_next_start,
    input  logic [AW-1:0] i_next_end,
    input  logic          i_valid,
    input  logic          i_p,
    output logic [AW-1:0] o_start,
    output logic [AW-1:0] o_end,
    output t_flags        o_flags,
    output logic          o_p
);

    logic [AW-1:0] r_start, r_end;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            C_KEEP: begin
            end
            C_TAKE_NEXT: begin
                r_start <= i_next_start;
                r_end   <= i_next_end;
            end
            C_TAKE_PREV: begin
                r_start <= i_prev_start;
                r_end   <= i_prev_end;
            end
            C_LOAD_NEW: begin
                r_start <= i_s;
                r_end   <= i_e;
            end
            C_SET_START:     r_start <= i_s;
            C_SET_END:       r_end   <= i_e;
            C_END_FROM_NEXT: r_end   <= i_next_end;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_flags.lt       = r_start < i_e;
        o_flags.enclosed = (r_start >= i_s) && (r_end <= i_e);
        o_flags.contain  = (r_start <= i_s) && (r_end >= i_e);
        o_flags.in_a     = (r_start >= i_s) && (r_start <= i_e);
        o_flags.in_b     = (r_end >= i_s) && (r_end <= i_e);
        o_flags.le       = r_start <= i_e;
        o_flags.zero     = r_start == '0;
    end

    assign o_p     = i_p & i_valid & o_flags.lt;
    assign o_start = r_start;
    assign o_end   = r_end;

endmodule

### rtl/core/angular_clip_range_set.sv
// Sorted set of disjoint angle intervals held in a row of 64 cells, one interval
// per cell, each cell comparing its interval against the current range in
// parallel and shifting to its neighbors. One result per command, shown for one
// cycle on o_valid; the receiver cannot stall it. busy stays high from acceptance
// until that cycle. A clear or unused opcode goes straight to the result; a check
// tests the range once per half (two halves when it wraps). An add runs, per half,
// the one-entry-per-cycle removal shift, dropping each stored interval that the
// range swallows, then, unless a stored interval already contains the range, one
// extend, merge or insert step.
module angular_clip_range_set
    import acrs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_opcode,
    input  logic [AW-1:0] i_start_angle,
    input  logic [AW-1:0] i_end_angle,
    output logic          o_valid,
    output logic          o_visible,
    output logic          o_table_full
);

    typedef enum logic [2:0] {S_IDLE, S_REMOVE, S_EXTEND, S_CHECK, S_FIN} t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_s, r_e, r_e_in;
    logic          r_pend, r_vis, r_full, r_valid;

    logic [AW-1:0] w_start [MAX_SPANS];
    logic [AW-1:0] w_end   [MAX_SPANS];
    t_flags        w_flags [MAX_SPANS];
    t_cell_op      w_op    [MAX_SPANS];
    logic [MAX_SPANS:0] w_p;

    t_vec v_valid, v_p, v_inside, v_contain, v_ina, v_inb, v_lt, v_merge;
    t_vec rm_x, rm_first, ex_x, ex_first, ins_x, ins_first;
    logic rm_any, rm_drop, ex_any, ex_start, merge, hidden, is_full;

    assign w_p[0] = 1'b1;

    genvar j;
    generate
        for (j = 0; j < MAX_SPANS; j++) begin : g_cell
            logic [AW-1:0] prev_s, prev_e, next_s, next_e;
            if (j == 0) begin : g_first
                assign prev_s = '0;
                assign prev_e = '0;
            end else begin : g_mid
                assign prev_s = w_start[j-1];
                assign prev_e = w_end[j-1];
            end
            if (j == MAX_SPANS - 1) begin : g_last
                assign next_s     = '0;
                assign next_e     = '0;
                assign v_merge[j] = 1'b0;
            end else begin : g_nlast
                assign next_s     = w_start[j+1];
                assign next_e     = w_end[j+1];
                assign v_merge[j] = v_valid[j+1] & w_flags[j+1].le;
            end

            assign v_valid[j]   = CW'(j) < r_count;
            assign v_p[j]       = w_p[j+1];
            assign v_inside[j]  = w_flags[j].enclosed;
            assign v_contain[j] = w_flags[j].contain;
            assign v_ina[j]     = w_flags[j].in_a;
            assign v_inb[j]     = w_flags[j].in_b;
            assign v_lt[j]      = w_flags[j].lt;

            acrs_cell u_cell (
                .i_clk        (i_clk),
                .i_op         (w_op[j]),
                .i_s          (r_s),
                .i_e          (r_e),
                .i_prev_start (prev_s),
                .i_prev_end   (prev_e),
                .i_next_start (next_s),
                .i_next_end   (next_e),
                .i_valid      (v_valid[j]),
                .i_p          (w_p[j]),
                .o_start      (w_start[j]),
                .o_end        (w_end[j]),
                .o_flags      (w_flags[j]),
                .o_p          (w_p[j+1])
            );
        end
    endgenerate

    always_comb begin
        t_vec tail;
        tail      = '0;
        rm_x      = v_p & (v_inside | v_contain);
        rm_first  = first_of(rm_x);
        rm_any    = |rm_x;
        rm_drop   = |(rm_first & v_inside);
        ex_x      = v_valid & (v_ina | v_inb);
        ex_first  = first_of(ex_x);
        ex_any    = |ex_x;
        ex_start  = |(ex_first & v_ina);
        merge     = |(ex_first & v_merge);
        ins_x     = ~(v_valid & v_lt);
        ins_first = first_of(ins_x);
        is_full   = r_count == CW'(MAX_SPANS);
        hidden    = ((r_e == '0) && (r_count != '0) && w_flags[0].zero) |
                    (|(v_p & v_contain));

        for (int k = 0; k < MAX_SPANS; k++) w_op[k] = C_KEEP;

        unique case (r_state)
            S_REMOVE: begin
                if (rm_any && rm_drop) begin
                    tail = from_first(rm_first);
                    for (int k = 0; k < MAX_SPANS; k++)
                        if (tail[k]) w_op[k] = C_TAKE_NEXT;
                end
            end
            S_EXTEND: begin
                if (ex_any) begin
                    tail = from_first(ex_first) & ~ex_first;
                    for (int k = 0; k < MAX_SPANS; k++) begin
                        if (ex_first[k]) begin
                            if (ex_start)   w_op[k] = C_SET_START;
                            else if (merge) w_op[k] = C_END_FROM_NEXT;
                            else            w_op[k] = C_SET_END;
                        end else if (tail[k] && !ex_start && merge) begin
                            w_op[k] = C_TAKE_NEXT;
                        end
                    end
                end else if (!is_full) begin
                    tail = from_first(ins_first) & ~ins_first;
                    for (int k = 0; k < MAX_SPANS; k++) begin
                        if (ins_first[k])  w_op[k] = C_LOAD_NEW;
                        else if (tail[k])  w_op[k] = C_TAKE_PREV;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_state == S_FIN;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_e_in <= i_end_angle;
                        r_s    <= i_start_angle;
                        r_e    <= (i_start_angle > i_end_angle) ? ANGLE_TOP : i_end_angle;
                        r_pend <= i_start_angle > i_end_angle;
                        r_vis  <= 1'b0;
                        r_full <= 1'b0;
                        unique case (i_opcode)
                            OP_ADD:   r_state <= S_REMOVE;
                            OP_CHECK: r_state <= S_CHECK;
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_FIN;
                            end
                            default:  r_state <= S_FIN;
                        endcase
                    end
                end
                S_REMOVE: begin
                    if (rm_any && rm_drop) begin
                        r_count <= r_count - 1'b1;
                    end else if (rm_any) begin
                        if (r_pend) begin
                            r_s <= '0; r_e <= r_e_in; r_pend <= 1'b0;
                            r_state <= S_REMOVE;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_EXTEND;
                    end
                end
                S_EXTEND: begin
                    if (ex_any) begin
                        if (!ex_start && merge) r_count <= r_count - 1'b1;
                    end else if (is_full) begin
                        r_full <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_pend) begin
                        r_s <= '0; r_e <= r_e_in; r_pend <= 1'b0;
                        r_state <= S_REMOVE;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_CHECK: begin
                    if (!hidden) r_vis <= 1'b1;
                    if (r_pend) begin
                        r_s <= '0; r_e <= r_e_in; r_pend <= 1'b0;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = r_state != S_IDLE;
    assign o_valid      = r_valid;
    assign o_visible    = r_vis;
    assign o_table_full = r_full;

endmodule

### rtl/core/acrs_checker.sv
module acrs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_visible,
    input logic o_table_full
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised after accept");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid) else $error("busy dropped without result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_visible && o_table_full)) else $error("both flags set");

endmodule

bind angular_clip_range_set acrs_checker u_acrs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_visible    (o_visible),
    .o_table_full (o_table_full)
);
